[rtl/core/assert_macros.svh]
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset too
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mpps_pkg.sv]
// types, codes and constants of the multi-policy process scheduler
package mpps_pkg;

   localparam int unsigned PROC_COUNT  = 4;
   localparam int unsigned MAX_TICKETS = 1000;
   localparam int unsigned TICKET_CAP  = MAX_TICKETS - 1;

   typedef logic [1:0]  proc_idx_type;
   typedef logic [9:0]  ticket_type;
   typedef logic [15:0] word_type;
   typedef logic [16:0] alu_word_type;

   typedef enum logic [1:0] {
      OP_YIELD = 2'd0,
      OP_EXIT  = 2'd1,
      OP_PRIO  = 2'd2,
      OP_SHARE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      MODE_RR     = 3'd0,
      MODE_STRICT = 3'd1,
      MODE_PRIO   = 3'd2,
      MODE_SHARE  = 3'd3,
      MODE_LOT    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CSR_MODE    = 3'd0,
      CSR_TIX_P1  = 3'd1,
      CSR_TIX_P2  = 3'd2,
      CSR_TIX_P3  = 3'd3,
      CSR_TIX_P4  = 3'd4
   } csr_index_type;

   typedef enum logic {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type   op;
      alu_word_type a;
      alu_word_type b;
   } alu_req_type;

   typedef struct packed {
      alu_word_type res;
      logic         borrow;
   } alu_rsp_type;

   localparam mode_type   RESET_MODE    = MODE_LOT;
   localparam ticket_type RESET_TICKETS = 10'd250;
   localparam word_type   LFSR_SEED     = 16'hBD11;

   function automatic ticket_type ticket_clamp(input ticket_type t);
      ticket_type cap;
      cap = ticket_type'(TICKET_CAP);
      return (t > cap) ? cap : t;
   endfunction

endpackage

[rtl/core/mpps_if.sv]
// request and response channel interfaces of the scheduler
interface mpps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] value;

   modport source (output valid, opcode, value, input ready);
   modport sink   (input valid, opcode, value, output ready);
endinterface

interface mpps_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] chosen_process;
   logic       all_done;

   modport source (output valid, chosen_process, all_done, input ready);
   modport sink   (input valid, chosen_process, all_done, output ready);
endinterface

[rtl/core/mpps_alu.sv]
// shared add / subtract-compare unit used by the compare, sum and remainder steps
module mpps_alu
   import mpps_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [17:0] sum;

   always_comb begin
      case (req.op)
         ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
         default: sum = '0;
      endcase
      rsp.res    = sum[16:0];
      rsp.borrow = (req.op == ALU_SUB) ? sum[17] : 1'b0;
   end

endmodule

[rtl/core/mpps_lfsr.sv]
// 16-bit fibonacci lfsr for lottery draws
module mpps_lfsr
   import mpps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   output word_type state
);

   word_type lfsr_ff, lfsr_in;
   logic     fb;

   always_comb begin
      fb      = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];
      lfsr_in = step ? {fb, lfsr_ff[15:1]} : lfsr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

   assign state = lfsr_ff;

`include "assert_macros.svh"
   `ASSERT_CLK(a_lfsr_nonzero, clock, reset, lfsr_ff != '0, "lfsr reached zero")
   `ASSERT_CLK(a_lfsr_hold, clock, reset, !step |=> $stable(lfsr_ff), "lfsr moved without step")

endmodule

[rtl/core/multi_policy_process_scheduler.sv]
// top level: event sequencer, process state and configuration of the scheduler
//
// channel  dir  payload                        beat
// req_ch   in   opcode[1:0], value[15:0]        valid & ready
// rsp_ch   out  chosen_process[2:0], all_done   valid & ready
// csr_*    in   index[2:0], wdata[9:0]          csr_we
//
// set priority / set share: done on accept. round robin, strict: scan from the next or
// first process. priority: minimum search, then scan. share: scan from the current one.
// lottery: sum tickets, then per draw an lfsr step, 16 restoring steps and the map.
// compares, sums and remainders go through one shared add/sub unit, one step per cycle.
// one event at a time: req_ch.ready is low from accept until the response beat.
// synchronous reset restores the sequencer, csrs, process state and the lfsr seed.
module multi_policy_process_scheduler
   import mpps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mpps_req_if.sink   req_ch,
   mpps_rsp_if.source rsp_ch,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_MIN, S_SHARE, S_SUM, S_STEP, S_DIV, S_MAP, S_RESP
   } state_type;

   state_type    state_ff, state_in;
   mode_type     mode_ff;
   ticket_type   tix_ff [PROC_COUNT];
   logic [3:0]   run_ff, run_in;
   word_type     prio_ff [PROC_COUNT], prio_in [PROC_COUNT];
   word_type     share_ff [PROC_COUNT], share_in [PROC_COUNT];
   word_type     runs_ff [PROC_COUNT], runs_in [PROC_COUNT];
   proc_idx_type cur_ff, cur_in;
   proc_idx_type idx_ff, idx_in;
   logic [2:0]   cnt_ff, cnt_in;
   alu_word_type best_ff, best_in;
   logic         eq_ff, eq_in;
   logic [11:0]  total_ff, total_in;
   logic         reach_ff, reach_in;
   logic [11:0]  rem_ff, rem_in;
   logic [3:0]   bit_ff, bit_in;
   logic [16:0]  draws_ff, draws_in;
   logic [2:0]   chosen_ff, chosen_in;
   logic         done_ff, done_in;
   logic         rsp_valid_ff, rsp_valid_in;

   alu_req_type  alu_req;
   alu_rsp_type  alu_rsp;
   word_type     lfsr;
   logic         lfsr_step;

   logic         finish, pick;
   proc_idx_type pick_idx;
   logic         redraw;
   ticket_type   tc;
   logic [12:0]  shifted;
   logic         accept;

   mpps_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   mpps_lfsr u_lfsr (
      .clock(clock),
      .reset(reset),
      .step(lfsr_step),
      .state(lfsr)
   );

   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      prio_in      = prio_ff;
      share_in     = share_ff;
      runs_in      = runs_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      eq_in        = eq_ff;
      total_in     = total_ff;
      reach_in     = reach_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      draws_in     = draws_ff;
      chosen_in    = chosen_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      lfsr_step    = 1'b0;
      finish       = 1'b0;
      pick         = 1'b0;
      pick_idx     = idx_ff;
      redraw       = 1'b0;
      tc           = ticket_clamp(tix_ff[idx_ff]);
      shifted      = {rem_ff, lfsr[bit_ff]};
      alu_req.op   = ALU_SUB;
      alu_req.a    = '0;
      alu_req.b    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_ch.opcode))
                  OP_PRIO: begin
                     prio_in[cur_ff] = req_ch.value;
                     finish   = 1'b1;
                     pick     = run_ff[cur_ff];
                     pick_idx = cur_ff;
                  end
                  OP_SHARE: begin
                     share_in[cur_ff] = req_ch.value;
                     finish   = 1'b1;
                     pick     = run_ff[cur_ff];
                     pick_idx = cur_ff;
                  end
                  default: begin
                     if (opcode_type'(req_ch.opcode) == OP_EXIT) run_in[cur_ff] = 1'b0;
                     cnt_in = '0;
                     eq_in  = 1'b0;
                     case (mode_ff)
                        MODE_RR: begin
                           idx_in   = cur_ff + 2'd1;
                           state_in = S_SCAN;
                        end
                        MODE_STRICT: begin
                           idx_in   = '0;
                           state_in = S_SCAN;
                        end
                        MODE_PRIO: begin
                           idx_in   = '0;
                           best_in  = 17'h10000;
                           state_in = S_MIN;
                        end
                        MODE_SHARE: begin
                           idx_in   = cur_ff;
                           state_in = S_SHARE;
                        end
                        MODE_LOT: begin
                           idx_in   = '0;
                           total_in = '0;
                           reach_in = 1'b0;
                           draws_in = '0;
                           state_in = S_SUM;
                        end
                        default: finish = 1'b1;
                     endcase
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (run_ff[idx_ff] && (!eq_ff || {1'b0, prio_ff[idx_ff]} == best_ff)) begin
               finish = 1'b1;
               pick   = 1'b1;
            end else if (cnt_ff == 3'd3) begin
               finish = 1'b1;
            end else begin
               idx_in = idx_ff + 2'd1;
               cnt_in = cnt_ff + 3'd1;
            end
         end
         S_MIN: begin
            alu_req.a = {1'b0, prio_ff[idx_ff]};
            alu_req.b = best_ff;
            if (run_ff[idx_ff] && alu_rsp.borrow) best_in = {1'b0, prio_ff[idx_ff]};
            idx_in = idx_ff + 2'd1;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               idx_in   = cur_ff + 2'd1;
               cnt_in   = '0;
               eq_in    = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SHARE: begin
            alu_req.a = {1'b0, runs_ff[idx_ff]};
            alu_req.b = {1'b0, share_ff[idx_ff]};
            if (run_ff[idx_ff] && alu_rsp.borrow) begin
               runs_in[idx_ff] = runs_ff[idx_ff] + 16'd1;
               finish = 1'b1;
               pick   = 1'b1;
            end else begin
               if (run_ff[idx_ff]) runs_in[idx_ff] = '0;
               if (cnt_ff == 3'd4) begin
                  finish = 1'b1;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         end
         S_SUM: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = {5'd0, total_ff};
            alu_req.b  = {7'd0, tc};
            total_in   = alu_rsp.res[11:0];
            reach_in   = reach_ff || (run_ff[idx_ff] && tc != '0);
            idx_in     = idx_ff + 2'd1;
            cnt_in     = cnt_ff + 3'd1;
            if (cnt_ff == 3'd3) begin
               if (total_in == '0 || !reach_in) begin
                  finish = 1'b1;
               end else begin
                  state_in = S_STEP;
               end
            end
         end
         S_STEP: begin
            lfsr_step = 1'b1;
            draws_in  = draws_ff + 17'd1;
            bit_in    = 4'd15;
            rem_in    = '0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            // restoring remainder, one draw bit per cycle
            alu_req.a = {4'd0, shifted};
            alu_req.b = {5'd0, total_ff};
            rem_in    = alu_rsp.borrow ? shifted[11:0] : alu_rsp.res[11:0];
            bit_in    = bit_ff - 4'd1;
            if (bit_ff == '0) begin
               idx_in   = '0;
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            alu_req.a = {5'd0, rem_ff};
            alu_req.b = {7'd0, tc};
            if (alu_rsp.borrow) begin
               if (run_ff[idx_ff]) begin
                  finish = 1'b1;
                  pick   = 1'b1;
               end else begin
                  redraw = 1'b1;
               end
            end else begin
               rem_in = alu_rsp.res[11:0];
               if (idx_ff == 2'd3) redraw = 1'b1;
               else idx_in = idx_ff + 2'd1;
            end
            if (redraw) begin
               // give up after 65536 draws
               if (draws_ff[16]) finish = 1'b1;
               else state_in = S_STEP;
            end
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (finish) begin
         state_in     = S_RESP;
         rsp_valid_in = 1'b1;
         chosen_in    = pick ? (3'({1'b0, pick_idx}) + 3'd1) : 3'd0;
         if (pick) cur_in = pick_idx;
         done_in      = ~|run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= RESET_MODE;
         run_ff       <= '1;
         cur_ff       <= '0;
         for (int i = 0; i < PROC_COUNT; i++) begin
            tix_ff[i]   <= RESET_TICKETS;
            prio_ff[i]  <= '0;
            share_ff[i] <= 16'd1;
            runs_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
         cur_ff       <= cur_in;
         prio_ff      <= prio_in;
         share_ff     <= share_in;
         runs_ff      <= runs_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:   mode_ff   <= mode_type'(csr_wdata[2:0]);
               CSR_TIX_P1: tix_ff[0] <= csr_wdata;
               CSR_TIX_P2: tix_ff[1] <= csr_wdata;
               CSR_TIX_P3: tix_ff[2] <= csr_wdata;
               CSR_TIX_P4: tix_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
      idx_ff    <= idx_in;
      cnt_ff    <= cnt_in;
      best_ff   <= best_in;
      eq_ff     <= eq_in;
      total_ff  <= total_in;
      reach_ff  <= reach_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      draws_ff  <= draws_in;
      chosen_ff <= chosen_in;
      done_ff   <= done_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.chosen_process = chosen_ff;
   assign rsp_ch.all_done       = done_ff;

`include "assert_macros.svh"
   `ASSERT_CLK(a_rsp_in_resp, clock, reset, rsp_valid_ff == (state_ff == S_RESP), "response flag out of step with sequencer")
   `ASSERT_CLK(a_chosen_runnable, clock, reset, rsp_valid_ff && chosen_ff != 3'd0 |-> run_ff[2'(chosen_ff - 3'd1)], "chosen process not runnable")
   `ASSERT_CLK(a_done_matches, clock, reset, rsp_valid_ff |-> done_ff == ~|run_ff, "all_done disagrees with runnable set")
   `ASSERT_CLK(a_pick_moves_cur, clock, reset, rsp_valid_ff && chosen_ff != 3'd0 |-> cur_ff == 2'(chosen_ff - 3'd1), "current process not updated to pick")

endmodule

[dv/tb_multi_policy_process_scheduler.sv]
// self-checking testbench of the multi-policy process scheduler
`timescale 1ns / 100ps

module tb_multi_policy_process_scheduler;
   import mpps_pkg::*;

   localparam int NPROC       = 4;
   localparam int MODE_UNDEF5 = 5;
   localparam int MODE_UNDEF7 = 7;
   localparam int SETTLE      = 40;

   typedef enum int {ITEM_EVENT, ITEM_CSR, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [2:0]    index;
      logic [9:0]    wdata;
      opcode_type    opcode;
      logic [15:0]   value;
   } pending_item_type;

   typedef struct {
      logic [2:0] chosen;
      logic       all_done;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we    = 1'b0;
   logic [2:0] csr_index = '0;
   logic [9:0] csr_wdata = '0;

   mpps_req_if req_bus ();
   mpps_rsp_if rsp_bus ();

   multi_policy_process_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pending_item_type pending_items[$];
   pick_type         expected_picks[$];
   int               error_count = 0;
   bit               req_taken = 0;
   bit               stim_done = 0;

   // scheduler state mirror
   int unsigned m_mode;
   int unsigned m_tickets[1:NPROC];
   bit          m_runnable[1:NPROC];
   logic [15:0] m_prio[1:NPROC];
   logic [15:0] m_share[1:NPROC];
   logic [15:0] m_runs[1:NPROC];
   int unsigned m_current;
   logic [15:0] m_lfsr;

   initial begin
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_YIELD;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
   end

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int unsigned step_proc(int unsigned p);
      return (p >= NPROC || p < 1) ? 1 : p + 1;
   endfunction

   function automatic int unsigned clamped_tickets(int unsigned p);
      return (m_tickets[p] > TICKET_CAP) ? TICKET_CAP : m_tickets[p];
   endfunction

   function automatic void mirror_reset();
      m_mode = RESET_MODE;
      for (int p = 1; p <= NPROC; p++) begin
         m_tickets[p]  = RESET_TICKETS;
         m_runnable[p] = 1;
         m_prio[p]     = '0;
         m_share[p]    = 16'd1;
         m_runs[p]     = '0;
      end
      m_current = 1;
      m_lfsr    = LFSR_SEED;
   endfunction

   function automatic void mirror_csr(logic [2:0] idx, logic [9:0] data);
      if (idx == CSR_MODE) m_mode = data[2:0];
      else if (idx <= CSR_TIX_P4) m_tickets[idx] = data;
   endfunction

   function automatic int unsigned pick_lottery();
      int unsigned total, r, p;
      bit reach;
      total = 0;
      reach = 0;
      for (p = 1; p <= NPROC; p++) begin
         total += clamped_tickets(p);
         if (m_runnable[p] && clamped_tickets(p) > 0) reach = 1;
      end
      if (total == 0 || !reach) return 0;
      for (int d = 0; d < 65536; d++) begin
         m_lfsr = {m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5], m_lfsr[15:1]};
         r = m_lfsr % total;
         for (p = 1; p <= NPROC; p++) begin
            if (r < clamped_tickets(p)) break;
            r -= clamped_tickets(p);
         end
         if (p <= NPROC && m_runnable[p]) return p;
      end
      return 0;
   endfunction

   function automatic pick_type schedule_event(opcode_type op, logic [15:0] val);
      pick_type    res;
      int unsigned cur, chosen, p, best;
      bit          any;
      cur = (m_current < 1 || m_current > NPROC) ? 1 : m_current;
      chosen = 0;
      if (op == OP_PRIO || op == OP_SHARE) begin
         if (op == OP_PRIO) m_prio[cur] = val;
         else m_share[cur] = val;
         chosen = m_runnable[cur] ? cur : 0;
      end else begin
         if (op == OP_EXIT) m_runnable[cur] = 0;
         case (m_mode)
            MODE_RR: begin
               p = m_current;
               for (int k = 0; k < NPROC; k++) begin
                  p = step_proc(p);
                  if (m_runnable[p]) begin chosen = p; break; end
               end
            end
            MODE_STRICT: begin
               for (p = 1; p <= NPROC; p++)
                  if (m_runnable[p]) begin chosen = p; break; end
            end
            MODE_PRIO: begin
               best = 32'h10000;
               for (p = 1; p <= NPROC; p++)
                  if (m_runnable[p] && m_prio[p] < best) best = m_prio[p];
               p = m_current;
               for (int k = 0; k < NPROC; k++) begin
                  p = step_proc(p);
                  if (m_runnable[p] && m_prio[p] == best) begin chosen = p; break; end
               end
            end
            MODE_SHARE: begin
               p = cur;
               for (int k = 0; k <= NPROC; k++) begin
                  if (m_runnable[p]) begin
                     if (m_runs[p] >= m_share[p]) m_runs[p] = '0;
                     else begin
                        m_runs[p]++;
                        chosen = p;
                        break;
                     end
                  end
                  p = step_proc(p);
               end
            end
            MODE_LOT: chosen = pick_lottery();
            default: chosen = 0;
         endcase
         if (chosen != 0) m_current = chosen;
      end
      any = 0;
      for (p = 1; p <= NPROC; p++) any |= m_runnable[p];
      res.chosen   = chosen[2:0];
      res.all_done = !any;
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void add_event(opcode_type op, logic [15:0] val);
      pending_item_type it;
      it.kind = ITEM_EVENT; it.opcode = op; it.value = val;
      it.index = '0; it.wdata = '0;
      pending_items.push_back(it);
   endfunction

   function automatic void add_drain();
      pending_item_type it;
      it.kind = ITEM_DRAIN; it.opcode = OP_YIELD; it.value = '0;
      it.index = '0; it.wdata = '0;
      pending_items.push_back(it);
   endfunction

   function automatic void add_csr(int idx, int data);
      pending_item_type it;
      add_drain();
      it.kind = ITEM_CSR; it.index = 3'(idx); it.wdata = 10'(data);
      it.opcode = OP_YIELD; it.value = '0;
      pending_items.push_back(it);
   endfunction

   function automatic void add_all_tickets(int t1, int t2, int t3, int t4);
      add_csr(CSR_TIX_P1, t1);
      add_csr(CSR_TIX_P2, t2);
      add_csr(CSR_TIX_P3, t3);
      add_csr(CSR_TIX_P4, t4);
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3));
         1: return 16'($urandom_range(0, 65535));
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic void build_stimulus();
      int mode;
      // directed: lottery at reset, ticket clamping, zero totals, then each mode and undefined modes
      add_event(OP_YIELD, 16'hFFFF);
      add_event(OP_YIELD, 16'h0000);
      add_all_tickets(1023, 1023, 1023, 1023);
      add_event(OP_YIELD, 16'hA5A5);
      add_all_tickets(0, 0, 0, 0);
      add_event(OP_YIELD, 16'h5A5A);
      add_all_tickets(0, 0, 0, 999);
      add_event(OP_YIELD, 16'h0001);
      add_all_tickets(250, 250, 250, 250);
      add_csr(CSR_MODE, MODE_RR);
      repeat (3) add_event(OP_YIELD, 16'h0000);
      add_csr(CSR_MODE, MODE_STRICT);
      add_event(OP_YIELD, 16'h0000);
      add_csr(CSR_MODE, MODE_PRIO);
      add_event(OP_PRIO, 16'hFFFF);
      add_event(OP_YIELD, 16'h0000);
      add_event(OP_PRIO, 16'h0000);
      repeat (2) add_event(OP_YIELD, 16'h0000);
      add_csr(CSR_MODE, MODE_SHARE);
      add_event(OP_SHARE, 16'h0000);
      add_event(OP_YIELD, 16'h0000);
      add_event(OP_SHARE, 16'hFFFF);
      repeat (2) add_event(OP_YIELD, 16'h0000);
      add_csr(CSR_MODE, MODE_UNDEF7);
      add_event(OP_YIELD, 16'h0000);
      add_csr(CSR_MODE, MODE_UNDEF5);
      add_event(OP_YIELD, 16'h0000);

      // random: each stage ends with one process leaving
      for (int stage = 0; stage < 4; stage++) begin
         for (int blk = 0; blk < 6; blk++) begin
            mode = ($urandom_range(0, 9) == 0) ? $urandom_range(MODE_UNDEF5, MODE_UNDEF7)
                                               : $urandom_range(MODE_RR, MODE_LOT);
            add_csr(CSR_MODE, mode);
            if (mode == MODE_LOT)
               add_all_tickets($urandom_range(300, 1023), $urandom_range(300, 1023),
                               $urandom_range(300, 1023), $urandom_range(300, 1023));
            repeat ($urandom_range(30, 45)) begin
               case ($urandom_range(0, 5))
                  0, 1, 2: add_event(OP_YIELD, 16'($urandom_range(0, 65535)));
                  3: add_event(OP_PRIO, rand_value());
                  default: add_event(OP_SHARE, rand_value());
               endcase
            end
         end
         add_event(OP_EXIT, 16'($urandom_range(0, 65535)));
      end
      // nothing runnable any more
      add_csr(CSR_MODE, MODE_LOT);
      repeat (20) add_event(opcode_type'($urandom_range(0, 3)),
                            16'($urandom_range(0, 65535)));
   endfunction

   initial begin
      mirror_reset();
      build_stimulus();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      wait (pending_items.size() == 0 && expected_picks.size() == 0 && !req_bus.valid);
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // sampling: prediction on accept, checking on response beats
   always @(posedge clock) begin
      pick_type got, want;
      if (!reset) begin
         if (csr_we) mirror_csr(csr_index, csr_wdata);
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1;
            expected_picks.push_back(schedule_event(opcode_type'(req_bus.opcode),
                                                    req_bus.value));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.chosen   = rsp_bus.chosen_process;
            got.all_done = rsp_bus.all_done;
            if (expected_picks.size() == 0) begin
               report_mismatch("unexpected beat chosen_process", got.chosen, -1);
            end else begin
               want = expected_picks.pop_front();
               if (got.chosen !== want.chosen)
                  report_mismatch("chosen_process", got.chosen, want.chosen);
               if (got.all_done !== want.all_done)
                  report_mismatch("all_done", got.all_done, want.all_done);
            end
         end
      end
   end

   // sender: bursts with gaps, csr writes and drains only when idle
   int burst_left = 0;
   int gap_left   = 0;
   int hold_left  = 0;

   always @(negedge clock) begin
      logic v;
      logic we;
      pending_item_type it;
      v  = req_bus.valid;
      we = 1'b0;
      if (!reset) begin
         if (req_taken) begin
            v = 1'b0;
            req_taken = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (!v && pending_items.size() > 0) begin
            it = pending_items[0];
            case (it.kind)
               ITEM_EVENT: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     void'(pending_items.pop_front());
                     v = 1'b1;
                     req_bus.opcode <= it.opcode;
                     req_bus.value  <= it.value;
                     if (burst_left > 0) burst_left--;
                     else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                     end
                  end
               end
               ITEM_CSR: begin
                  void'(pending_items.pop_front());
                  we = 1'b1;
                  csr_index <= it.index;
                  csr_wdata <= it.wdata;
               end
               default: begin
                  if (expected_picks.size() == 0) begin
                     void'(pending_items.pop_front());
                     hold_left = SETTLE;
                  end
               end
            endcase
         end
      end
      req_bus.valid <= v;
      csr_we <= we;
   end

   // receiver: stall rate is redrawn whenever its random timer runs out
   int stall_pct   = 0;
   int stall_timer = 0;

   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_timer = $urandom_range(100, 400);
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 95;
         endcase
      end else begin
         stall_timer--;
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mpps_pkg.sv
rtl/core/mpps_if.sv
rtl/core/mpps_alu.sv
rtl/core/mpps_lfsr.sv
rtl/core/multi_policy_process_scheduler.sv
dv/tb_multi_policy_process_scheduler.sv
